// ===== rtl/core/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants for the line raster block with reflection.
// ----------------------------------------------------------------------------
package lrr_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int SCREEN_W       = 10;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int REFL_W         = 3;
  localparam int OUT_W          = ((2 * SCREEN_W + 7) / 8) * 8;

  localparam logic [REFL_W-1:0]   REFLECT_RST  = 3'd0;
  localparam logic [SCREEN_W-1:0] ORIGIN_X_RST = 10'd512;
  localparam logic [SCREEN_W-1:0] ORIGIN_Y_RST = 10'd384;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DRAW
  } state_t;

  typedef enum logic [REFL_W-1:0] {
    REFL_NONE  = 3'd0,
    REFL_XAXIS = 3'd1,
    REFL_YAXIS = 3'd2,
    REFL_DIAG  = 3'd3,
    REFL_ANTI  = 3'd4
  } refl_t;

  typedef enum logic [1:0] {
    SLOPE_GENTLE_UP   = 2'd0,
    SLOPE_GENTLE_DOWN = 2'd1,
    SLOPE_STEEP_UP    = 2'd2,
    SLOPE_STEEP_DOWN  = 2'd3
  } slope_t;

  typedef enum logic [1:0] {
    REG_REFLECT  = 2'd0,
    REG_ORIGIN_X = 2'd1,
    REG_ORIGIN_Y = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [REFL_W-1:0]   reflect_mode;
    logic [SCREEN_W-1:0] origin_x;
    logic [SCREEN_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

endpackage

// ===== rtl/core/line_raster_with_reflection_top.sv =====
// ----------------------------------------------------------------------------
// line_raster_with_reflection_top
// Line segment rasterizer with selectable reflection, midpoint stepping.
//
//   channel  dir  handshake               payload
//   in_*     in   in_tvalid/in_tready     start_x, start_y, end_x, end_y
//   out_*    out  out_tvalid/out_tready   pixel_x, pixel_y; tlast = last_pixel
//   cfg_*    in   apb psel/penable        reflect_mode @0, origin_x @4, origin_y @8
//
// A segment is taken, its slope is set up, and then the stepping loop emits
// one pixel per cycle while the output is free.
// The next segment is taken the cycle after its last pixel is emitted.
// A stalled output holds the stepper; reset is synchronous and leaves the
// block idle with the registers at their defaults.
// ----------------------------------------------------------------------------
module line_raster_with_reflection_top #(
  parameter int COORD_BITS = lrr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // start_x, start_y, end_x, end_y, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pixel_x, pixel_y, zero fill
  output logic [lrr_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lrr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lrr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lrr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import lrr_pkg::*;

  cfg_t                cfg;
  cmd_t                cmd;
  sts_t                sts;
  logic [SCREEN_W-1:0] pixel_x, pixel_y;

  lrr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .start_x    (in_tdata[COORD_BITS-1:0]),
    .start_y    (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x      (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y      (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (out_tlast)
  );

  assign out_tdata = {(OUT_W - 2 * SCREEN_W)'(0), pixel_y, pixel_x};

endmodule

// ===== rtl/core/lrr_cfg.sv =====
// ----------------------------------------------------------------------------
// lrr_cfg
// Configuration registers behind the bus port: reflection mode and origin.
// ----------------------------------------------------------------------------
module lrr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lrr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lrr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lrr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output lrr_pkg::cfg_t                  cfg
);
  import lrr_pkg::*;

  logic [REFL_W-1:0]   reflect_r, reflect_nxt;
  logic [SCREEN_W-1:0] origin_x_r, origin_x_nxt;
  logic [SCREEN_W-1:0] origin_y_r, origin_y_nxt;
  logic                wr;
  reg_idx_t            idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    reflect_nxt  = reflect_r;
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    if (wr) begin
      unique case (idx)
        REG_REFLECT:  reflect_nxt  = cfg_pwdata[REFL_W-1:0];
        REG_ORIGIN_X: origin_x_nxt = cfg_pwdata[SCREEN_W-1:0];
        REG_ORIGIN_Y: origin_y_nxt = cfg_pwdata[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reflect_r  <= REFLECT_RST;
      origin_x_r <= ORIGIN_X_RST;
      origin_y_r <= ORIGIN_Y_RST;
    end else begin
      reflect_r  <= reflect_nxt;
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_REFLECT:  cfg_prdata = CFG_DATA_W'(reflect_r);
      REG_ORIGIN_X: cfg_prdata = CFG_DATA_W'(origin_x_r);
      REG_ORIGIN_Y: cfg_prdata = CFG_DATA_W'(origin_y_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg.reflect_mode = reflect_r;
  assign cfg.origin_x     = origin_x_r;
  assign cfg.origin_y     = origin_y_r;

endmodule

// ===== rtl/core/lrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrr_ctrl
// Sequencer: take a segment, set up the slope, then one pixel per free slot.
// ----------------------------------------------------------------------------
module lrr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lrr_pkg::sts_t sts,
  output lrr_pkg::cmd_t cmd
);
  import lrr_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_DRAW;
      ST_DRAW:  if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_DRAW:  cmd.emit  = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/lrr_dp.sv =====
// ----------------------------------------------------------------------------
// lrr_dp
// Datapath: reflection and endpoint ordering, slope setup, midpoint stepping
// and the output word register.
// ----------------------------------------------------------------------------
module lrr_dp #(
  parameter int COORD_BITS = lrr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lrr_pkg::cfg_t                cfg,
  input  lrr_pkg::cmd_t                cmd,
  output lrr_pkg::sts_t                sts,
  input  logic [COORD_BITS-1:0]        start_x,
  input  logic [COORD_BITS-1:0]        start_y,
  input  logic [COORD_BITS-1:0]        end_x,
  input  logic [COORD_BITS-1:0]        end_y,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [lrr_pkg::SCREEN_W-1:0] pixel_x,
  output logic [lrr_pkg::SCREEN_W-1:0] pixel_y,
  output logic                         last_pixel
);
  import lrr_pkg::*;

  localparam int LW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 4;

  // endpoints after reflection and ordering
  logic signed [LW-1:0] p1x_r, p1y_r, p2x_r, p2y_r;
  logic signed [LW-1:0] cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic signed [DW-1:0] dec_r, dec_nxt;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic [COORD_BITS-1:0] steps_r, steps_nxt;
  slope_t                slope_r, slope_nxt;

  logic signed [LW-1:0] sx, sy, ex, ey;
  logic signed [LW-1:0] ax, ay, bx, by;
  logic signed [DW-1:0] dx, dy, dec_init;
  logic [COORD_BITS-1:0] steps_init;

  logic                  out_valid_r;
  logic [SCREEN_W-1:0]   pix_x_r, pix_y_r;
  logic                  last_r;

  assign sx = LW'(signed'(start_x));
  assign sy = LW'(signed'(start_y));
  assign ex = LW'(signed'(end_x));
  assign ey = LW'(signed'(end_y));

  always_comb begin
    logic signed [LW-1:0] tx, ty;
    tx = '0;
    ty = '0;
    ax = sx;
    ay = sy;
    bx = ex;
    by = ey;
    unique case (refl_t'(cfg.reflect_mode))
      REFL_XAXIS: begin
        ay = -sy;
        by = -ey;
      end
      REFL_YAXIS: begin
        ax = -sx;
        bx = -ex;
      end
      REFL_DIAG: begin
        ax = sy;
        ay = sx;
        bx = ey;
        by = ex;
      end
      REFL_ANTI: begin
        ax = -sy;
        ay = -sx;
        bx = -ey;
        by = -ex;
      end
      default: ;
    endcase
    // order by x, so a vertical segment runs from end to start
    if (ax >= bx) begin
      tx = ax;
      ty = ay;
      ax = bx;
      ay = by;
      bx = tx;
      by = ty;
    end
  end

  assign dx = DW'(p2x_r) - DW'(p1x_r);
  assign dy = DW'(p2y_r) - DW'(p1y_r);

  always_comb begin
    priority if (dx == 0 && dy == 0) begin
      slope_nxt  = SLOPE_GENTLE_UP;
      steps_init = '0;
      dec_init   = '0;
    end else if (dy > 0 && dy <= dx) begin
      slope_nxt  = SLOPE_GENTLE_UP;
      steps_init = COORD_BITS'(dx);
      dec_init   = dx - dy - dy;
    end else if (dy <= 0 && -dy <= dx) begin
      slope_nxt  = SLOPE_GENTLE_DOWN;
      steps_init = COORD_BITS'(dx);
      dec_init   = -dx - dy - dy;
    end else if (dy > dx) begin
      slope_nxt  = SLOPE_STEEP_UP;
      steps_init = COORD_BITS'(dy);
      dec_init   = dx + dx - dy;
    end else begin
      slope_nxt  = SLOPE_STEEP_DOWN;
      steps_init = COORD_BITS'(-dy);
      dec_init   = -dx - dx - dy;
    end
  end

  // one midpoint step
  always_comb begin
    logic neg;
    neg       = dec_r[DW-1];
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    dec_nxt   = dec_r;
    unique case (slope_r)
      SLOPE_GENTLE_UP: begin
        cur_x_nxt = cur_x_r + LW'(1);
        if (neg) begin
          cur_y_nxt = cur_y_r + LW'(1);
          dec_nxt   = dec_r + dx2_r - dy2_r;
        end else begin
          dec_nxt   = dec_r - dy2_r;
        end
      end
      SLOPE_GENTLE_DOWN: begin
        cur_x_nxt = cur_x_r + LW'(1);
        if (neg) begin
          dec_nxt   = dec_r - dy2_r;
        end else begin
          cur_y_nxt = cur_y_r - LW'(1);
          dec_nxt   = dec_r - dx2_r - dy2_r;
        end
      end
      SLOPE_STEEP_UP: begin
        cur_y_nxt = cur_y_r + LW'(1);
        if (neg) begin
          dec_nxt   = dec_r + dx2_r;
        end else begin
          cur_x_nxt = cur_x_r + LW'(1);
          dec_nxt   = dec_r + dx2_r - dy2_r;
        end
      end
      default: begin
        cur_y_nxt = cur_y_r - LW'(1);
        if (neg) begin
          cur_x_nxt = cur_x_r + LW'(1);
          dec_nxt   = dec_r - dx2_r - dy2_r;
        end else begin
          dec_nxt   = dec_r - dx2_r;
        end
      end
    endcase
    steps_nxt = steps_r - COORD_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p1x_r <= ax;
      p1y_r <= ay;
      p2x_r <= bx;
      p2y_r <= by;
    end
    if (cmd.setup) begin
      cur_x_r <= p1x_r;
      cur_y_r <= p1y_r;
      dec_r   <= dec_init;
      dx2_r   <= dx + dx;
      dy2_r   <= dy + dy;
      steps_r <= steps_init;
      slope_r <= slope_nxt;
    end else if (cmd.emit && steps_r != '0) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      dec_r   <= dec_nxt;
      steps_r <= steps_nxt;
    end
    if (cmd.emit) begin
      pix_x_r <= cfg.origin_x + SCREEN_W'(cur_x_r);
      pix_y_r <= cfg.origin_y - SCREEN_W'(cur_y_r);
      last_r  <= (steps_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.last     = (steps_r == '0);

  assign out_tvalid = out_valid_r;
  assign pixel_x    = pix_x_r;
  assign pixel_y    = pix_y_r;
  assign last_pixel = last_r;

`ifndef SYNTH
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !sts.last |=> steps_r == $past(steps_r) - COORD_BITS'(1))
    else $error("step count did not advance by one");

  a_ends_on_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.last |-> cur_x_r == p2x_r && cur_y_r == p2y_r)
    else $error("walk did not finish on the far endpoint");

  a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("pixel word lost after emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_tready)
    else $error("emit over a word still waiting");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for line_raster_with_reflection_top. Segments go in on the input
// stream. Every accepted segment is rasterised by a predictor inside a small
// scoreboard. Every pixel word that comes out is compared field by field with
// the oldest predicted pixel. Reflection and origin registers are rewritten
// over the apb port between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrr_pkg::*;

  typedef struct packed {
    logic [SCREEN_W-1:0] px;
    logic [SCREEN_W-1:0] py;
    logic                last;
  } pixel_t;

  class raster_scoreboard;
    pixel_t              pixel_q[$];
    logic [REFL_W-1:0]   mode;
    logic [SCREEN_W-1:0] org_x;
    logic [SCREEN_W-1:0] org_y;
    int                  errors;

    function new();
      mode   = REFLECT_RST;
      org_x  = ORIGIN_X_RST;
      org_y  = ORIGIN_Y_RST;
      errors = 0;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR %0t: %s", $realtime, msg);
    endtask

    // indexes outside the register map are dropped
    function void write_reg(int idx, logic [31:0] val);
      case (idx)
        REG_REFLECT:  mode  = val[REFL_W-1:0];
        REG_ORIGIN_X: org_x = val[SCREEN_W-1:0];
        REG_ORIGIN_Y: org_y = val[SCREEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_pixel(logic signed [6:0] lx, logic signed [6:0] ly, logic last);
      pixel_t p;
      p.px   = SCREEN_W'(int'(org_x) + int'(lx));
      p.py   = SCREEN_W'(int'(org_y) - int'(ly));
      p.last = last;
      pixel_q.push_back(p);
    endfunction

    // walks one segment with the doubled midpoint decision
    function void note_segment(logic [23:0] word);
      logic signed [6:0] x1, y1, x2, y2, t;
      logic signed [7:0] dx, dy;
      logic signed [6:0] cur_x, cur_y;
      logic signed [8:0] dec;
      logic [6:0]        steps;
      slope_t            cls;
      logic              neg;
      x1 = 7'($signed(word[5:0]));
      y1 = 7'($signed(word[11:6]));
      x2 = 7'($signed(word[17:12]));
      y2 = 7'($signed(word[23:18]));
      case (mode)
        REFL_XAXIS: begin
          y1 = -y1;
          y2 = -y2;
        end
        REFL_YAXIS: begin
          x1 = -x1;
          x2 = -x2;
        end
        REFL_DIAG: begin
          t = x1; x1 = y1; y1 = t;
          t = x2; x2 = y2; y2 = t;
        end
        REFL_ANTI: begin
          t = x1; x1 = -y1; y1 = -t;
          t = x2; x2 = -y2; y2 = -t;
        end
        default: ;
      endcase
      if (x1 >= x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx    = 8'(x2) - 8'(x1);
      dy    = 8'(y2) - 8'(y1);
      cur_x = x1;
      cur_y = y1;
      if (dx == 0 && dy == 0) begin
        cls   = SLOPE_GENTLE_UP;
        steps = 0;
        dec   = 0;
      end else if (dy > 0 && dy <= dx) begin
        cls   = SLOPE_GENTLE_UP;
        steps = 7'(dx);
        dec   = 9'(dx - 2 * dy);
      end else if (dy <= 0 && -dy <= dx) begin
        cls   = SLOPE_GENTLE_DOWN;
        steps = 7'(dx);
        dec   = 9'(-dx - 2 * dy);
      end else if (dy > dx) begin
        cls   = SLOPE_STEEP_UP;
        steps = 7'(dy);
        dec   = 9'(2 * dx - dy);
      end else begin
        cls   = SLOPE_STEEP_DOWN;
        steps = 7'(-dy);
        dec   = 9'(-2 * dx - dy);
      end
      push_pixel(cur_x, cur_y, steps == 0);
      while (steps > 0) begin
        neg = dec < 0;
        case (cls)
          SLOPE_GENTLE_UP: begin
            cur_x = cur_x + 1;
            if (neg) begin
              cur_y = cur_y + 1;
              dec   = 9'(dec + 2 * dx - 2 * dy);
            end else begin
              dec = 9'(dec - 2 * dy);
            end
          end
          SLOPE_GENTLE_DOWN: begin
            cur_x = cur_x + 1;
            if (neg) begin
              dec = 9'(dec - 2 * dy);
            end else begin
              cur_y = cur_y - 1;
              dec   = 9'(dec - 2 * dx - 2 * dy);
            end
          end
          SLOPE_STEEP_UP: begin
            cur_y = cur_y + 1;
            if (neg) begin
              dec = 9'(dec + 2 * dx);
            end else begin
              cur_x = cur_x + 1;
              dec   = 9'(dec + 2 * dx - 2 * dy);
            end
          end
          default: begin
            cur_y = cur_y - 1;
            if (neg) begin
              cur_x = cur_x + 1;
              dec   = 9'(dec - 2 * dx - 2 * dy);
            end else begin
              dec = 9'(dec - 2 * dx);
            end
          end
        endcase
        steps = steps - 1;
        push_pixel(cur_x, cur_y, steps == 0);
      end
    endfunction

    task check_pixel(logic [SCREEN_W-1:0] px, logic [SCREEN_W-1:0] py, logic last);
      pixel_t e;
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected pixel x=%0d y=%0d last=%0d", px, py, last));
      end else begin
        e = pixel_q.pop_front();
        if (px !== e.px)
          report($sformatf("pixel_x got %0d expected %0d", px, e.px));
        if (py !== e.py)
          report($sformatf("pixel_y got %0d expected %0d", py, e.py));
        if (last !== e.last)
          report($sformatf("last_pixel got %0d expected %0d (x=%0d y=%0d)",
                           last, e.last, e.px, e.py));
      end
    endtask
  endclass

  localparam int ITEMS_PER_PHASE = 36;
  localparam int NUM_PHASES      = 10;
  localparam int HOLD_CYCLES     = 300;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  // start_x, start_y, end_x, end_y
  logic [23:0]           in_tdata    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // pixel_x, pixel_y, zero fill
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  raster_scoreboard sb = new();
  bit               no_idle  = 1'b0;
  bit               hold_req = 1'b0;

  line_raster_with_reflection_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_segment(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_pixel(out_tdata[9:0], out_tdata[19:10], out_tlast);
    end
  end

  // receiver: random stalls, always ready in the no-idle phase, or a long hold-off when asked
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 32);
      end
    end
  end

  task apb_write(int idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx * 4);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task send_segment(logic signed [5:0] sx, logic signed [5:0] sy,
                    logic signed [5:0] ex, logic signed [5:0] ey);
    if (!no_idle && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ey, ex, sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wait for every pixel, then let the block settle
  task settle();
    in_tvalid <= 1'b0;
    // let the monitor note the word taken at this edge first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function logic [5:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 6'h20;
    if (r < 20) return 6'h1f;
    if (r < 25) return 6'h00;
    return 6'($urandom_range(63));
  endfunction

  initial begin : stimulus
    logic [5:0] sx, sy, ex, ey;
    int         mode_set[NUM_PHASES] = '{1, 2, 3, 4, 5, 0, 6, 7, 4, 3};
    int         ox_set[NUM_PHASES]   = '{32, 991, 0, 1023, 512, 200, 991, 32, 700, 0};
    int         oy_set[NUM_PHASES]   = '{991, 32, 1023, 0, 384, 600, 991, 32, 250, 1023};
    int         guard;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: slope classes, extremes, zero length, flat and vertical
    send_segment(0, 0, 0, 0);
    send_segment(-32, 31, -32, 31);
    send_segment(-32, -32, 31, 31);
    send_segment(31, 31, -32, -32);
    send_segment(-32, 31, 31, -32);
    send_segment(-32, 0, 31, 0);
    send_segment(5, -32, 5, 31);
    send_segment(0, 0, 10, 3);
    send_segment(0, 0, 10, -4);
    send_segment(0, 0, 3, 10);
    send_segment(-2, 5, 1, -9);
    send_segment(0, 0, 7, 7);
    send_segment(0, 0, 7, -7);
    send_segment(-32, -32, -31, 31);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      apb_write(REG_REFLECT, 32'(mode_set[p]));
      apb_write(REG_ORIGIN_X, 32'(ox_set[p]));
      apb_write(REG_ORIGIN_Y, 32'(oy_set[p]));
      // an unmapped register index must not disturb anything
      if (p == 1)
        apb_write(3, 32'hffff_ffff);
      no_idle = (p == 5);
      // receiver holds off while the sender keeps offering
      if (p == 2)
        hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        sx = pick_coord();
        sy = pick_coord();
        if ($urandom_range(99) < 40) begin
          ex = sx + 6'($urandom_range(8)) - 6'd4;
          ey = sy + 6'($urandom_range(8)) - 6'd4;
        end else begin
          ex = pick_coord();
          ey = pick_coord();
        end
        send_segment(sx, sy, ex, ey);
      end
    end

    in_tvalid <= 1'b0;
    no_idle = 1'b0;
    guard = 0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d pixels never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== line_raster_with_reflection_top.f =====
rtl/core/lrr_pkg.sv
rtl/core/lrr_cfg.sv
rtl/core/lrr_ctrl.sv
rtl/core/lrr_dp.sv
rtl/core/line_raster_with_reflection_top.sv
verif/tb.sv
